FILE: rtl/source_text_tokenizer_assert.svh
// Assertion macros shared by the tokenizer sources.
// Every property is sampled on the rising edge of clock and is disabled while reset is high.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/stt_pkg.sv
package stt_pkg;

   // Result bookkeeping.
   localparam int MAX_RESULTS     = 3;
   localparam int COUNT_W         = $clog2(MAX_RESULTS + 1);
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int KIND_W          = 4;

   // Lexeme kinds as reported on the result channel.
   typedef enum logic [KIND_W-1:0] {
      KIND_SPACE   = 4'd0,
      KIND_NEWLINE = 4'd1,
      KIND_CHAR    = 4'd2,
      KIND_STRING  = 4'd3,
      KIND_NUM     = 4'd4,
      KIND_COMMENT = 4'd5,
      KIND_INVALID = 4'd6,
      KIND_SYMBOL  = 4'd7,
      KIND_END     = 4'd8
   } kind_type;

   // Status from the lexer to the top level.
   typedef struct packed {
      logic               ended;
      logic [COUNT_W-1:0] res_count;
   } lex_status_type;

   // Character codes.
   localparam logic [7:0] CH_END       = 8'h00;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_UNIT_SEP  = 8'h1F;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_AT        = 8'h40;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_BACKTICK  = 8'h60;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_DEL       = 8'h7F;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Control bytes other than NUL and newline, and DEL, are invalid lexemes.
   function automatic logic is_invalid(input logic [7:0] c);
      return ((c != CH_END) && (c <= CH_UNIT_SEP) && (c != CH_NEWLINE)) || (c == CH_DEL);
   endfunction

   // Delimiters that form runs of the same byte.
   function automatic logic is_repeat(input logic [7:0] c);
      logic r;
      case (c) inside
         CH_SPACE, CH_BACKTICK, CH_DOT, CH_COMMA, CH_SEMI: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Bytes that end a symbol or numeric lexeme.
   function automatic logic is_delim(input logic [7:0] c);
      logic r;
      case (c) inside
         CH_END, CH_AT, CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET,
         CH_LBRACE, CH_RBRACE, CH_DQUOTE, CH_NEWLINE: r = 1'b1;
         default: r = is_invalid(c) || is_repeat(c);
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/stt_lexer.sv
module stt_lexer
   import stt_pkg::*;
#(
   parameter int LENGTH_WIDTH = 16,
   parameter int LINE_WIDTH   = 24,
   parameter int COLUMN_WIDTH = 16,
   parameter int OFFSET_WIDTH = 24,
   parameter int RES_W        = 1 + KIND_W + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH
                                + COLUMN_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           text_byte,
   output lex_status_type       status,
   output logic [RES_W-1:0]     res_data [MAX_RESULTS]
);

   typedef enum logic [3:0] {
      M_IDLE, M_LINE, M_BLOCK_OPEN, M_BLOCK, M_NLRUN, M_QUOTE, M_NUM, M_SYM, M_RUN, M_DONE
   } mode_type;

   typedef enum logic [1:0] {
      DIR_NONE, DIR_STAR, DIR_NAME
   } dir_type;

   typedef struct packed {
      logic                    last;
      logic [COLUMN_WIDTH-1:0] col;
      logic [LINE_WIDTH-1:0]   line;
      logic [LENGTH_WIDTH-1:0] len;
      logic [OFFSET_WIDTH-1:0] off;
      kind_type                kind;
   } res_type;

   localparam logic [LENGTH_WIDTH-1:0] LEN_ONE  = LENGTH_WIDTH'(1);
   localparam logic [LENGTH_WIDTH-1:0] LEN_TWO  = LENGTH_WIDTH'(2);
   localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
   localparam logic [COLUMN_WIDTH-1:0] COL_ONE  = COLUMN_WIDTH'(1);
   localparam logic [OFFSET_WIDTH-1:0] OFF_ONE  = OFFSET_WIDTH'(1);

   function automatic logic [LENGTH_WIDTH-1:0] sat_len(input logic [LENGTH_WIDTH-1:0] v);
      return (&v) ? v : v + LEN_ONE;
   endfunction

   function automatic logic [LINE_WIDTH-1:0] sat_line(input logic [LINE_WIDTH-1:0] v);
      return (&v) ? v : v + LINE_ONE;
   endfunction

   function automatic logic [COLUMN_WIDTH-1:0] sat_col(input logic [COLUMN_WIDTH-1:0] v);
      return (&v) ? v : v + COL_ONE;
   endfunction

   function automatic logic [OFFSET_WIDTH-1:0] sat_off(input logic [OFFSET_WIDTH-1:0] v);
      return (&v) ? v : v + OFF_ONE;
   endfunction

   // State registers.
   mode_type                mode_ff, mode_in;
   logic [7:0]              la_ff, la_in;
   logic                    la_valid_ff, la_valid_in;
   logic [7:0]              run_ff, run_in;
   logic                    esc_ff, esc_in;
   logic                    dec_ff, dec_in;
   dir_type                 dir_ff, dir_in;
   logic                    ended_ff, ended_in;
   logic [OFFSET_WIDTH-1:0] cur_off_ff, cur_off_in;
   logic [LINE_WIDTH-1:0]   cur_line_ff, cur_line_in;
   logic [COLUMN_WIDTH-1:0] cur_col_ff, cur_col_in;
   logic [OFFSET_WIDTH-1:0] tok_off_ff, tok_off_in;
   logic [LENGTH_WIDTH-1:0] tok_len_ff, tok_len_in;
   logic [LINE_WIDTH-1:0]   tok_line_ff, tok_line_in;
   logic [COLUMN_WIDTH-1:0] tok_col_ff, tok_col_in;
   kind_type                tok_kind_ff, tok_kind_in;

   // Working values for one step.
   logic [7:0]              cur_byte;
   logic                    do_proc;
   logic                    ext;
   mode_type                mode_x;
   logic                    esc_x, dec_x;
   dir_type                 dir_x;
   logic                    close_a, close_b, emit_end, start_new;
   mode_type                start_mode;
   kind_type                start_kind;
   logic [LINE_WIDTH-1:0]   line_c;
   logic [COLUMN_WIDTH-1:0] col_c;
   mode_type                mode_p;
   logic                    esc_p, dec_p;
   dir_type                 dir_p;
   logic [7:0]              run_p;
   logic [OFFSET_WIDTH-1:0] off_p, tok_off_p;
   logic [LENGTH_WIDTH-1:0] tok_len_p;
   logic [LINE_WIDTH-1:0]   line_p, tok_line_p, line_f;
   logic [COLUMN_WIDTH-1:0] col_p, tok_col_p, col_f;
   kind_type                kind_p;
   res_type                 res_a, res_b, res_c;

   assign cur_byte = la_ff;
   assign do_proc  = la_valid_ff && !ended_ff;

   // Try to extend the open lexeme with the held byte.
   always_comb begin
      ext    = 1'b0;
      mode_x = mode_ff;
      esc_x  = esc_ff;
      dec_x  = dec_ff;
      dir_x  = dir_ff;
      unique case (mode_ff)
         M_LINE: begin
            if (cur_byte != CH_NEWLINE) begin
               ext = 1'b1;
               if ((tok_len_ff == LEN_TWO) && (cur_byte == CH_STAR)) begin
                  dir_x = DIR_STAR;
               end else if ((dir_ff == DIR_STAR) && (cur_byte != CH_SPACE)) begin
                  dir_x = DIR_NAME;
               end
            end
         end
         M_BLOCK_OPEN: begin
            ext    = 1'b1;
            mode_x = M_BLOCK;
            esc_x  = 1'b0;
         end
         M_BLOCK: begin
            ext = 1'b1;
            if (esc_ff && (cur_byte == CH_RBRACE)) begin
               mode_x = M_DONE;
            end else begin
               esc_x = (cur_byte == CH_EQUAL);
            end
         end
         M_NLRUN: ext = (cur_byte == CH_SPACE);
         M_QUOTE: begin
            if (esc_ff) begin
               ext   = 1'b1;
               esc_x = 1'b0;
            end else if (cur_byte == CH_NEWLINE) begin
               ext = 1'b0;
            end else if (cur_byte == CH_BACKSLASH) begin
               ext   = 1'b1;
               esc_x = 1'b1;
            end else begin
               ext = 1'b1;
               if (cur_byte == run_ff) begin
                  mode_x = M_DONE;
               end
            end
         end
         M_NUM: begin
            if (!is_delim(cur_byte)) begin
               ext = 1'b1;
            end else if ((cur_byte == CH_DOT) && !dec_ff && is_digit(text_byte)) begin
               ext   = 1'b1;
               dec_x = 1'b1;
            end
         end
         M_SYM:   ext = !is_delim(cur_byte);
         M_RUN:   ext = (cur_byte == run_ff);
         default: ext = 1'b0;
      endcase
   end

   // Classify a lexeme that starts with the held byte.
   always_comb begin
      if ((cur_byte == CH_MINUS) && (text_byte == CH_MINUS)) begin
         start_mode = M_LINE;
         start_kind = KIND_COMMENT;
      end else if ((cur_byte == CH_LBRACE) && (text_byte == CH_EQUAL)) begin
         start_mode = M_BLOCK_OPEN;
         start_kind = KIND_COMMENT;
      end else if (cur_byte == CH_NEWLINE) begin
         start_mode = M_NLRUN;
         start_kind = KIND_NEWLINE;
      end else if (cur_byte == CH_SQUOTE) begin
         start_mode = M_QUOTE;
         start_kind = KIND_CHAR;
      end else if (cur_byte == CH_DQUOTE) begin
         start_mode = M_QUOTE;
         start_kind = KIND_STRING;
      end else if (is_digit(cur_byte) ||
                   (((cur_byte == CH_PLUS) || (cur_byte == CH_MINUS)) && is_digit(text_byte)))
      begin
         start_mode = M_NUM;
         start_kind = KIND_NUM;
      end else if (!is_delim(cur_byte)) begin
         start_mode = M_SYM;
         start_kind = KIND_SYMBOL;
      end else if (is_repeat(cur_byte)) begin
         start_mode = M_RUN;
         start_kind = (cur_byte == CH_SPACE) ? KIND_SPACE : KIND_SYMBOL;
      end else begin
         start_mode = M_DONE;
         start_kind = is_invalid(cur_byte) ? KIND_INVALID : KIND_SYMBOL;
      end
   end

   // Close the open lexeme if the byte does not extend it; a directive comment
   // moves the location on its close.
   assign close_a   = do_proc && (mode_ff != M_IDLE) && !ext;
   assign start_new = do_proc && !((mode_ff != M_IDLE) && ext);

   always_comb begin
      line_c = cur_line_ff;
      col_c  = cur_col_ff;
      if (close_a && (mode_ff == M_LINE) && (dir_ff != DIR_NONE)) begin
         line_c = (dir_ff == DIR_NAME) ? LINE_ONE : '0;
         col_c  = '0;
      end
   end

   // State after the held byte is placed, either extending or starting a lexeme.
   always_comb begin
      mode_p     = mode_ff;
      esc_p      = esc_ff;
      dec_p      = dec_ff;
      dir_p      = dir_ff;
      run_p      = run_ff;
      tok_off_p  = tok_off_ff;
      tok_len_p  = tok_len_ff;
      tok_line_p = tok_line_ff;
      tok_col_p  = tok_col_ff;
      kind_p     = tok_kind_ff;
      off_p      = cur_off_ff;
      line_p     = cur_line_ff;
      col_p      = cur_col_ff;
      if (start_new) begin
         mode_p     = start_mode;
         esc_p      = 1'b0;
         dec_p      = 1'b0;
         dir_p      = DIR_NONE;
         run_p      = cur_byte;
         tok_off_p  = cur_off_ff;
         tok_len_p  = LEN_ONE;
         tok_line_p = line_c;
         tok_col_p  = col_c;
         kind_p     = start_kind;
      end else if (do_proc) begin
         mode_p    = mode_x;
         esc_p     = esc_x;
         dec_p     = dec_x;
         dir_p     = dir_x;
         tok_len_p = sat_len(tok_len_ff);
      end
      if (do_proc) begin
         off_p = sat_off(cur_off_ff);
         if (cur_byte == CH_NEWLINE) begin
            line_p = sat_line(line_c);
            col_p  = COL_ONE;
         end else begin
            line_p = line_c;
            col_p  = sat_col(col_c);
         end
      end
   end

   // End of text flushes the open lexeme and reports END.
   assign emit_end = ended_ff || (text_byte == CH_END);
   assign close_b  = !ended_ff && (text_byte == CH_END) && (mode_p != M_IDLE);

   always_comb begin
      line_f = line_p;
      col_f  = col_p;
      if (close_b && (mode_p == M_LINE) && (dir_p != DIR_NONE)) begin
         line_f = (dir_p == DIR_NAME) ? LINE_ONE : '0;
         col_f  = '0;
      end
   end

   // Candidate results in model order.
   always_comb begin
      res_a.last = !emit_end;
      res_a.col  = tok_col_ff;
      res_a.line = tok_line_ff;
      res_a.len  = tok_len_ff;
      res_a.off  = tok_off_ff;
      res_a.kind = tok_kind_ff;
      res_b.last = 1'b0;
      res_b.col  = tok_col_p;
      res_b.line = tok_line_p;
      res_b.len  = tok_len_p;
      res_b.off  = tok_off_p;
      res_b.kind = kind_p;
      res_c.last = 1'b1;
      res_c.col  = col_f;
      res_c.line = line_f;
      res_c.len  = '0;
      res_c.off  = off_p;
      res_c.kind = KIND_END;
   end

   // Pack present results into the lowest slots.
   always_comb begin
      res_data[0] = close_a ? res_a : (close_b ? res_b : res_c);
      res_data[1] = (close_a && close_b) ? res_b : res_c;
      res_data[2] = res_c;
   end

   assign status.ended     = ended_ff;
   assign status.res_count = COUNT_W'(close_a) + COUNT_W'(close_b) + COUNT_W'(emit_end);

   // Next state for an accepted byte.
   always_comb begin
      mode_in     = close_b ? M_IDLE : mode_p;
      esc_in      = close_b ? 1'b0 : esc_p;
      dec_in      = close_b ? 1'b0 : dec_p;
      dir_in      = close_b ? DIR_NONE : dir_p;
      run_in      = run_p;
      tok_off_in  = tok_off_p;
      tok_len_in  = tok_len_p;
      tok_line_in = tok_line_p;
      tok_col_in  = tok_col_p;
      tok_kind_in = kind_p;
      cur_off_in  = off_p;
      cur_line_in = line_f;
      cur_col_in  = col_f;
      la_in       = text_byte;
      la_valid_in = (text_byte != CH_END) && !ended_ff;
      ended_in    = emit_end;
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         la_ff       <= '0;
         la_valid_ff <= 1'b0;
         run_ff      <= '0;
         esc_ff      <= 1'b0;
         dec_ff      <= 1'b0;
         dir_ff      <= DIR_NONE;
         ended_ff    <= 1'b0;
         cur_off_ff  <= '0;
         cur_line_ff <= LINE_ONE;
         cur_col_ff  <= COL_ONE;
         tok_off_ff  <= '0;
         tok_len_ff  <= '0;
         tok_line_ff <= LINE_ONE;
         tok_col_ff  <= COL_ONE;
         tok_kind_ff <= KIND_SPACE;
      end else if (byte_valid) begin
         mode_ff     <= mode_in;
         la_ff       <= la_in;
         la_valid_ff <= la_valid_in;
         run_ff      <= run_in;
         esc_ff      <= esc_in;
         dec_ff      <= dec_in;
         dir_ff      <= dir_in;
         ended_ff    <= ended_in;
         cur_off_ff  <= cur_off_in;
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         tok_off_ff  <= tok_off_in;
         tok_len_ff  <= tok_len_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         tok_kind_ff <= tok_kind_in;
      end
   end

endmodule

FILE: rtl/stt_rsp_queue.sv
module stt_rsp_queue
   import stt_pkg::*;
#(
   parameter int WIDTH = 85
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] push_count,
   input  logic [WIDTH-1:0]   push_data [MAX_RESULTS],
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [WIDTH-1:0]   out_data
);

   localparam int DEPTH = RSP_QUEUE_DEPTH;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SEL_W = $clog2(MAX_RESULTS);

   logic [WIDTH-1:0] ent_ff [DEPTH];
   logic [WIDTH-1:0] ent_in [DEPTH];
   logic [WIDTH-1:0] shift_src [DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] base;
   logic             pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = ent_ff[0];
   assign pop       = out_valid && out_ready;
   assign in_ready  = (cnt_ff <= CNT_W'(DEPTH - MAX_RESULTS));
   assign base      = cnt_ff - CNT_W'(pop);
   assign cnt_in    = base + CNT_W'(push_count);

   // Each entry keeps its value, takes the one above on a transfer out, or
   // takes a new result appended behind the survivors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      logic [CNT_W-1:0] slot;

      if (i < DEPTH - 1) begin : g_upper
         assign shift_src[i] = ent_ff[i+1];
      end else begin : g_top
         assign shift_src[i] = ent_ff[i];
      end

      assign slot = CNT_W'(i) - base;

      always_comb begin
         if (CNT_W'(i) < base) begin
            ent_in[i] = pop ? shift_src[i] : ent_ff[i];
         end else if (slot < CNT_W'(push_count)) begin
            ent_in[i] = push_data[slot[SEL_W-1:0]];
         end else begin
            ent_in[i] = ent_ff[i];
         end
      end
   end

   // Entry payload.
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/source_text_tokenizer.sv
// Accepts one text byte per cycle while req_tready is high; one byte is held as lookahead,
// so a lexeme is reported when the second byte past its end is transferred, or at the latest
// by the end byte. With an empty queue a result is on rsp in the cycle after the byte that
// closes it. The end byte yields up to three results; the four-entry result queue drains
// them one per cycle while rsp_tready is high, and req_tready is low while it holds more
// than one. Synchronous active-high reset returns to the start of text at line 1, column 1.
`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int LENGTH_WIDTH = 16,
   parameter int LINE_WIDTH   = 24,
   parameter int COLUMN_WIDTH = 16,
   parameter int OFFSET_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // text_byte
   input  logic [7:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // kind, start_offset, lexeme_length, line_number, column_number, zero fill
   output logic [((KIND_W + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH + COLUMN_WIDTH + 7) / 8)
                 * 8 - 1:0] rsp_tdata,
   output logic rsp_tlast
);

   localparam int DATA_W  = KIND_W + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH + COLUMN_WIDTH;
   localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;
   localparam int RES_W   = DATA_W + 1;
   localparam int LEN_LO  = KIND_W + OFFSET_WIDTH;

   logic                 fire;
   lex_status_type       status;
   logic [RES_W-1:0]     res_data [MAX_RESULTS];
   logic [COUNT_W-1:0]   push_count;
   logic [RES_W-1:0]     out_word;
   logic [KIND_W-1:0]    out_kind;
   logic [LENGTH_WIDTH-1:0] out_len;

   assign fire       = req_tvalid && req_tready;
   assign push_count = fire ? status.res_count : '0;

   // Lexer state and per-byte result formation.
   stt_lexer #(
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .LINE_WIDTH   (LINE_WIDTH),
      .COLUMN_WIDTH (COLUMN_WIDTH),
      .OFFSET_WIDTH (OFFSET_WIDTH),
      .RES_W        (RES_W)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (fire),
      .text_byte  (req_tdata),
      .status     (status),
      .res_data   (res_data)
   );

   // Result queue between the lexer and the output channel.
   stt_rsp_queue #(
      .WIDTH (RES_W)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (res_data),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_word)
   );

   // Output transfer fields.
   assign rsp_tdata = TDATA_W'(out_word[DATA_W-1:0]);
   assign rsp_tlast = out_word[DATA_W];
   assign out_kind  = out_word[KIND_W-1:0];
   assign out_len   = out_word[LEN_LO +: LENGTH_WIDTH];

   `STT_ASSERT_IMPLIES(a_end_is_last,
      rsp_tvalid && (out_kind == KIND_END), rsp_tlast, "END result without tlast")
   `STT_ASSERT_IMPLIES(a_lexeme_nonempty,
      rsp_tvalid && (out_kind != KIND_END), out_len != '0, "empty lexeme reported")
   `STT_ASSERT_IMPLIES(a_ended_single,
      fire && status.ended, status.res_count == COUNT_W'(1),
      "after end each byte must give one END")
   `STT_ASSERT_NEXT(a_end_byte_ends,
      fire && (req_tdata == CH_END), status.ended, "end byte did not end the text")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import stt_pkg::*;

   localparam int OFFSET_W    = 24;
   localparam int LENGTH_W    = 16;
   localparam int LINE_W      = 24;
   localparam int COLUMN_W    = 16;
   localparam int RSP_W       = ((KIND_W + OFFSET_W + LENGTH_W + LINE_W + COLUMN_W + 7) / 8) * 8;
   localparam int TEXT_BYTES  = 430;
   localparam int HOLD_AT     = 200;
   localparam int TAIL_CYCLES = 20;

   // Scanner states of the predictor.
   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_LINE_COMMENT, SCAN_BLOCK_OPEN, SCAN_BLOCK, SCAN_NEWLINE_RUN,
      SCAN_QUOTE, SCAN_NUMBER, SCAN_SYMBOL, SCAN_RUN, SCAN_CLOSED
   } scan_state_type;

   // Progress through a location directive ("--*" line comment).
   typedef enum logic [1:0] {DIR_NONE, DIR_STAR, DIR_NAMED} directive_type;

   typedef struct {
      kind_type              kind;
      logic [OFFSET_W-1:0]   start_offset;
      logic [LENGTH_W-1:0]   lexeme_length;
      logic [LINE_W-1:0]     line_number;
      logic [COLUMN_W-1:0]   column_number;
      logic                  last;
   } lexeme_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;

   // Text still to be streamed and lexemes still to be reported.
   logic [7:0] source_bytes[$];
   lexeme_type pending_lexemes[$];

   // Predictor state.
   scan_state_type scan_state      = SCAN_IDLE;
   directive_type  directive_state = DIR_NONE;
   logic [7:0]  held_byte       = 8'h00;
   logic        held_valid      = 1'b0;
   logic [7:0]  run_byte        = 8'h00;
   logic        escape_open     = 1'b0;
   logic        fraction_seen   = 1'b0;
   logic        text_done       = 1'b0;
   logic [31:0] pos_offset = 0, pos_line = 1, pos_column = 1;
   logic [31:0] lex_offset = 0, lex_length = 0, lex_line = 1, lex_column = 1;
   kind_type    lex_kind   = KIND_SPACE;

   // Run bookkeeping.
   int mismatches      = 0;
   int bytes_sent      = 0;
   int lexemes_checked = 0;
   int directives_seen = 0;
   logic [8:0] kinds_seen = '0;
   int burst_left = 0;
   int gap_left   = 0;
   int ready_cycle = 0;
   int ready_mode  = 0;

   source_text_tokenizer #(
      .LENGTH_WIDTH(LENGTH_W),
      .LINE_WIDTH  (LINE_W),
      .COLUMN_WIDTH(COLUMN_W),
      .OFFSET_WIDTH(OFFSET_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- byte classes

   function automatic logic digit_byte(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic control_byte(input logic [7:0] c);
      return ((c != CH_END) && (c <= CH_UNIT_SEP) && (c != CH_NEWLINE)) || (c == CH_DEL);
   endfunction

   function automatic logic run_capable(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_BACKTICK) || (c == CH_DOT) || (c == CH_COMMA) ||
             (c == CH_SEMI);
   endfunction

   function automatic logic ends_word(input logic [7:0] c);
      return (c == CH_END) || control_byte(c) || run_capable(c) || (c == CH_AT) ||
             (c == CH_DOLLAR) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
             (c == CH_LBRACKET) || (c == CH_RBRACKET) || (c == CH_LBRACE) ||
             (c == CH_RBRACE) || (c == CH_DQUOTE) || (c == CH_NEWLINE);
   endfunction

   function automatic logic [31:0] sat_up(input logic [31:0] v, input int w);
      logic [32:0] top;
      top = (33'd1 << w) - 33'd1;
      return ({1'b0, v} < top) ? v + 32'd1 : v;
   endfunction

   // ---------------------------------------------------------------- predictor

   task automatic emit_lexeme(input kind_type kind, input logic [31:0] off,
                              input logic [31:0] len, input logic [31:0] line,
                              input logic [31:0] col);
      pending_lexemes.push_back('{kind, off[OFFSET_W-1:0], len[LENGTH_W-1:0],
                                  line[LINE_W-1:0], col[COLUMN_W-1:0], 1'b0});
   endtask

   // Account one byte to the open lexeme and to the running location.
   task automatic advance(input logic [7:0] c);
      lex_length = sat_up(lex_length, LENGTH_W);
      pos_offset = sat_up(pos_offset, OFFSET_W);
      if (c == CH_NEWLINE) begin
         pos_line   = sat_up(pos_line, LINE_W);
         pos_column = 1;
      end else begin
         pos_column = sat_up(pos_column, COLUMN_W);
      end
   endtask

   // Report the open lexeme; a finished directive moves the location.
   task automatic close_lexeme();
      emit_lexeme(lex_kind, lex_offset, lex_length, lex_line, lex_column);
      if (scan_state == SCAN_LINE_COMMENT && directive_state != DIR_NONE) begin
         pos_line   = (directive_state == DIR_NAMED) ? 1 : 0;
         pos_column = 0;
         directives_seen++;
      end
      scan_state      = SCAN_IDLE;
      directive_state = DIR_NONE;
      escape_open     = 1'b0;
      fraction_seen   = 1'b0;
   endtask

   // Decide whether c still belongs to the open lexeme, given the byte after it.
   function automatic logic extends_lexeme(input logic [7:0] c, input logic [7:0] nxt);
      logic grow;
      grow = 1'b1;
      case (scan_state)
         SCAN_LINE_COMMENT: begin
            if (c == CH_NEWLINE)
               grow = 1'b0;
            else if (lex_length == 2 && c == CH_STAR)
               directive_state = DIR_STAR;
            else if (directive_state == DIR_STAR && c != CH_SPACE)
               directive_state = DIR_NAMED;
         end
         SCAN_BLOCK_OPEN: begin
            scan_state  = SCAN_BLOCK;
            escape_open = 1'b0;
         end
         SCAN_BLOCK: begin
            if (escape_open && c == CH_RBRACE)
               scan_state = SCAN_CLOSED;
            else
               escape_open = (c == CH_EQUAL);
         end
         SCAN_NEWLINE_RUN: grow = (c == CH_SPACE);
         SCAN_QUOTE: begin
            if (escape_open)
               escape_open = 1'b0;
            else if (c == CH_NEWLINE)
               grow = 1'b0;
            else if (c == CH_BACKSLASH)
               escape_open = 1'b1;
            else if (c == run_byte)
               scan_state = SCAN_CLOSED;
         end
         SCAN_NUMBER: begin
            if (ends_word(c)) begin
               if (c == CH_DOT && !fraction_seen && digit_byte(nxt))
                  fraction_seen = 1'b1;
               else
                  grow = 1'b0;
            end
         end
         SCAN_SYMBOL: grow = !ends_word(c);
         SCAN_RUN:    grow = (c == run_byte);
         default:     grow = 1'b0;
      endcase
      return grow;
   endfunction

   task automatic open_lexeme(input logic [7:0] c, input logic [7:0] nxt);
      lex_offset      = pos_offset;
      lex_length      = 0;
      lex_line        = pos_line;
      lex_column      = pos_column;
      escape_open     = 1'b0;
      fraction_seen   = 1'b0;
      directive_state = DIR_NONE;
      run_byte        = c;
      if (c == CH_MINUS && nxt == CH_MINUS) begin
         scan_state = SCAN_LINE_COMMENT;
         lex_kind   = KIND_COMMENT;
      end else if (c == CH_LBRACE && nxt == CH_EQUAL) begin
         scan_state = SCAN_BLOCK_OPEN;
         lex_kind   = KIND_COMMENT;
      end else if (c == CH_NEWLINE) begin
         scan_state = SCAN_NEWLINE_RUN;
         lex_kind   = KIND_NEWLINE;
      end else if (c == CH_SQUOTE) begin
         scan_state = SCAN_QUOTE;
         lex_kind   = KIND_CHAR;
      end else if (c == CH_DQUOTE) begin
         scan_state = SCAN_QUOTE;
         lex_kind   = KIND_STRING;
      end else if (digit_byte(c) || ((c == CH_PLUS || c == CH_MINUS) && digit_byte(nxt))) begin
         scan_state = SCAN_NUMBER;
         lex_kind   = KIND_NUM;
      end else if (!ends_word(c)) begin
         scan_state = SCAN_SYMBOL;
         lex_kind   = KIND_SYMBOL;
      end else if (run_capable(c)) begin
         scan_state = SCAN_RUN;
         lex_kind   = (c == CH_SPACE) ? KIND_SPACE : KIND_SYMBOL;
      end else begin
         scan_state = SCAN_CLOSED;
         lex_kind   = control_byte(c) ? KIND_INVALID : KIND_SYMBOL;
      end
      advance(c);
   endtask

   task automatic consume(input logic [7:0] c, input logic [7:0] nxt);
      if (scan_state != SCAN_IDLE) begin
         if (extends_lexeme(c, nxt)) begin
            advance(c);
            return;
         end
         close_lexeme();
      end
      open_lexeme(c, nxt);
   endtask

   // One transferred byte: the held byte is scanned now that its successor is known.
   task automatic tokenize_byte(input logic [7:0] c);
      int first;
      first = pending_lexemes.size();
      if (text_done) begin
         emit_lexeme(KIND_END, pos_offset, 0, pos_line, pos_column);
      end else if (c != CH_END) begin
         if (held_valid)
            consume(held_byte, c);
         held_byte  = c;
         held_valid = 1'b1;
      end else begin
         if (held_valid)
            consume(held_byte, CH_END);
         held_valid = 1'b0;
         if (scan_state != SCAN_IDLE)
            close_lexeme();
         emit_lexeme(KIND_END, pos_offset, 0, pos_line, pos_column);
         text_done = 1'b1;
      end
      if (pending_lexemes.size() > first)
         pending_lexemes[pending_lexemes.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- text generation

   task automatic add_byte(input logic [7:0] c);
      source_bytes.push_back(c);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         source_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] any_text_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] symbol_byte();
      string extra;
      extra = "+-*=/<>!_#~";
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(8'h61, 8'h7A));
         1:       return 8'($urandom_range(128, 255));
         default: return extra[$urandom_range(0, extra.len() - 1)];
      endcase
   endfunction

   function automatic logic [7:0] digit_char();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Mostly well-formed lexemes with random content, with some noise mixed in.
   task automatic add_fragment();
      logic [7:0] q;
      logic [7:0] b;
      string runs;
      string singles;
      runs    = " `.,;";
      singles = "@$()[]{}";
      case ($urandom_range(0, 19))
         0, 1, 18: begin
            add_text("--");
            if ($urandom_range(0, 2) != 0) begin
               add_byte(CH_STAR);
               repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
               if ($urandom_range(0, 1) == 1)
                  repeat ($urandom_range(1, 4)) add_byte(symbol_byte());
            end else begin
               repeat ($urandom_range(0, 8)) begin
                  b = any_text_byte();
                  add_byte((b == CH_NEWLINE) ? CH_SPACE : b);
               end
            end
            add_byte(CH_NEWLINE);
         end
         2, 3: begin
            add_text("{=");
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 3))
                  0:       add_byte(CH_EQUAL);
                  1:       add_byte(CH_RBRACE);
                  default: add_byte(any_text_byte());
               endcase
            end
            add_text("=}");
         end
         4, 5: begin
            add_byte(CH_NEWLINE);
            repeat ($urandom_range(0, 3)) add_byte(CH_SPACE);
         end
         6, 7: begin
            q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
            add_byte(q);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 3) == 0) begin
                  add_byte(CH_BACKSLASH);
                  add_byte(any_text_byte());
               end else begin
                  b = any_text_byte();
                  add_byte((b == q || b == CH_BACKSLASH || b == CH_NEWLINE) ? 8'h78 : b);
               end
            end
            // An unterminated quote ends at the newline.
            add_byte(($urandom_range(0, 5) == 0) ? CH_NEWLINE : q);
         end
         8, 9, 10: begin
            case ($urandom_range(0, 3))
               0: add_byte(CH_PLUS);
               1: add_byte(CH_MINUS);
               default: ;
            endcase
            repeat ($urandom_range(1, 4)) add_byte(digit_char());
            if ($urandom_range(0, 1) == 1) begin
               add_byte(CH_DOT);
               repeat ($urandom_range(1, 3)) add_byte(digit_char());
               if ($urandom_range(0, 3) == 0) begin
                  add_byte(CH_DOT);
                  add_byte(digit_char());
               end
            end
         end
         11, 12, 13: repeat ($urandom_range(1, 6)) add_byte(symbol_byte());
         14, 15: begin
            b = runs[$urandom_range(0, runs.len() - 1)];
            repeat ($urandom_range(1, 4)) add_byte(b);
         end
         16: add_byte(singles[$urandom_range(0, singles.len() - 1)]);
         17: repeat ($urandom_range(1, 3)) add_byte(any_text_byte());
         default: add_byte(CH_SPACE);
      endcase
   endtask

   // ---------------------------------------------------------------- request driver

   // Sends the text in bursts; at one point it waits until all lexemes are reported.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata);
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (bytes_sent == HOLD_AT && pending_lexemes.size() != 0) begin
               req_tvalid <= 1'b0;
            end else if (source_bytes.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= source_bytes.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_lexeme();
      lexeme_type want;
      logic [3:0] got_kind;
      got_kind = rsp_tdata[KIND_W-1:0];
      if (pending_lexemes.size() == 0) begin
         $display("%0t: unexpected lexeme, expected none, got kind %0d at offset %0d",
                  $time, got_kind, rsp_tdata[KIND_W +: OFFSET_W]);
         mismatches++;
         return;
      end
      want = pending_lexemes.pop_front();
      check_field("kind", want.kind, got_kind);
      check_field("start_offset", want.start_offset, rsp_tdata[KIND_W +: OFFSET_W]);
      check_field("lexeme_length", want.lexeme_length,
                  rsp_tdata[KIND_W + OFFSET_W +: LENGTH_W]);
      check_field("line_number", want.line_number,
                  rsp_tdata[KIND_W + OFFSET_W + LENGTH_W +: LINE_W]);
      check_field("column_number", want.column_number,
                  rsp_tdata[KIND_W + OFFSET_W + LENGTH_W + LINE_W +: COLUMN_W]);
      check_field("last", want.last, rsp_tlast);
      kinds_seen[want.kind] = 1'b1;
      lexemes_checked++;
   endtask

   // The receiver stall pattern changes during the run; it is redrawn at random from four modes.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_lexeme();
         ready_cycle++;
         if (ready_cycle % 64 == 0)
            ready_mode = $urandom_range(0, 3);
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((ready_cycle % 16) >= 11);
         endcase
      end
   end

   // ---------------------------------------------------------------- stimulus and end of run

   initial begin
      // Directed text: named directive, tight block comment, escaped character,
      // signed decimal, delimiter run, invalid and high bytes, newline with indent.
      add_text("--* f\n");
      add_text("{==}");
      add_text("'\\''");
      add_text("-7.25");
      add_text("..");
      add_byte(8'h01);
      add_byte(CH_DEL);
      add_byte(8'h80);
      add_byte(8'hFF);
      add_text("\n  (");
      while (source_bytes.size() < TEXT_BYTES)
         add_fragment();
      // End of text, then bytes that must each repeat the end lexeme.
      add_byte(CH_END);
      repeat (3) add_byte(8'($urandom_range(0, 255)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (source_bytes.size() != 0 || req_tvalid || pending_lexemes.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pending_lexemes.size() != 0) begin
         $display("%0t: %0d lexemes never reported", $time, pending_lexemes.size());
         mismatches++;
      end
      $display("Streamed %0d text bytes with %0d location directives; %0d lexemes checked.",
               bytes_sent, directives_seen, lexemes_checked);
      $display("Lexeme kinds reported (one bit per kind, end kind highest): %b", kinds_seen);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
